// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the fill engine RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define AST_HOLDS(lbl, clk, rstn, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) prop) \
		else $error(msg);

// Expression must never be true outside reset.
`define AST_NEVER(lbl, clk, rstn, expr, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) !(expr)) \
		else $error(msg);

`endif

// ===== hdl/crfe_pkg.sv =====
// Types and constants of the clipped rectangle fill engine.
`default_nettype none

package crfe_pkg;

	localparam int CNT_W   = 18;
	localparam int COORD_W = 16;
	localparam int PIX_W   = 16;
	localparam logic [PIX_W-1:0] WHITE = 16'hFFFF;

	typedef logic signed [COORD_W-1:0] coord_t;

	typedef enum logic [1:0] {
		ACT_FILL  = 2'd0,
		ACT_READ  = 2'd1,
		ACT_CLEAR = 2'd2,
		ACT_NONE  = 2'd3
	} action_t;

	typedef struct packed {
		logic [1:0]         action;
		logic               landscape;
		logic signed [11:0] x_pos;
		logic signed [11:0] y_pos;
		logic signed [11:0] rect_width;
		logic signed [11:0] rect_height;
		logic [PIX_W-1:0]   color;
	} cmd_word_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             outside;
		logic [CNT_W-1:0] written_count;
	} rsp_word_t;

	typedef enum logic [3:0] {
		S_IDLE,
		S_ROT,
		S_CLIP,
		S_SETUP,
		S_FILL,
		S_CLEAR,
		S_RADDR,
		S_RISSUE,
		S_RDATA,
		S_DONE
	} state_t;

	function automatic coord_t sx12(logic signed [11:0] v);
		return coord_t'(v);
	endfunction

endpackage

`default_nettype wire

// ===== hdl/crfe_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read.
`default_nettype none

module crfe_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic                     rd_en,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data <= mem[rd_addr];
		end
	end

endmodule

`default_nettype wire

// ===== hdl/clipped_rect_fill_engine.sv =====
// Clipped rectangle fill engine: top level with frame store and sequencer.
//
//   channel | dir | handshake           | word
//   --------+-----+---------------------+-----------------------------
//   cmd     | in  | cmd_valid/cmd_stall | fill, read, clear or no-op request
//   rsp     | out | rsp_valid/rsp_stall | pixel, outside, written_count
//
// One item at a time; the frame store has one write and one read port.
// Fill: rotate, clip and setup states, then one pixel write per cycle over the
//   clipped area, then done; an empty clipped area goes from clip straight to done.
// Read: address, RAM read, data, done; straight to done when outside the panel.
// Clear: white over the whole store, then done; back to idle before the next cmd.
// Reset clears control only; store contents stay undefined until written.
// A finished word waits in the output register while the next cmd is taken;
// a further result waits in the done state until rsp_stall drops.
`default_nettype none
`include "assert_macros.svh"

module clipped_rect_fill_engine #(
	parameter int PANEL_WIDTH  = 368,
	parameter int PANEL_HEIGHT = 448
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cmd_valid,
	output logic                cmd_stall,
	input  crfe_pkg::cmd_word_t cmd,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output crfe_pkg::rsp_word_t rsp
);
	import crfe_pkg::*;

	localparam int DEPTH  = PANEL_WIDTH * PANEL_HEIGHT;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CW     = $clog2(PANEL_WIDTH + 1);
	localparam int RW     = $clog2(PANEL_HEIGHT + 1);
	localparam int PW     = CW + RW;

	state_t state_q, state_d;
	cmd_word_t cmd_q;
	rsp_word_t res_q, rsp_q;
	logic rsp_valid_q;

	coord_t rx_q, ry_q, rw_q, rh_q;
	logic [CW-1:0] cx_q, cw_q, col_q;
	logic [RW-1:0] cy_q, ch_q, row_q;
	logic empty_q;
	logic [ADDR_W-1:0] addr_q, row_base_q;

	logic accept, load;
	logic wr_en, rd_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [PIX_W-1:0] wr_data, rd_data;

	// clipping
	coord_t xe, ye, xl, yl, xr, yb, wc, hc;
	logic clip_empty;
	// read bounds
	coord_t px, py;
	logic rd_outside;
	// fill stepping
	logic col_last, row_last, clr_last;
	logic [ADDR_W-1:0] base_d;
	logic [PW-1:0] area_d;

	assign accept = cmd_valid && !cmd_stall;

	always_comb begin
		xe = rx_q + rw_q;
		ye = ry_q + rh_q;
		xl = (rx_q < coord_t'(0)) ? coord_t'(0) : rx_q;
		yl = (ry_q < coord_t'(0)) ? coord_t'(0) : ry_q;
		xr = (xe > coord_t'(PANEL_WIDTH)) ? coord_t'(PANEL_WIDTH) : xe;
		yb = (ye > coord_t'(PANEL_HEIGHT)) ? coord_t'(PANEL_HEIGHT) : ye;
		wc = xr - xl;
		hc = yb - yl;
		clip_empty = (wc <= coord_t'(0)) || (hc <= coord_t'(0));
	end

	always_comb begin
		px = sx12(cmd_q.x_pos);
		py = sx12(cmd_q.y_pos);
		rd_outside = (px < coord_t'(0)) || (px >= coord_t'(PANEL_WIDTH)) ||
			(py < coord_t'(0)) || (py >= coord_t'(PANEL_HEIGHT));
	end

	assign base_d   = ADDR_W'(cy_q) * ADDR_W'(PANEL_WIDTH) + ADDR_W'(cx_q);
	assign area_d   = PW'(cw_q) * PW'(ch_q);
	assign col_last = (col_q == cw_q - CW'(1));
	assign row_last = (row_q == ch_q - RW'(1));
	assign clr_last = (addr_q == ADDR_W'(DEPTH - 1));

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					unique case (action_t'(cmd.action))
						ACT_FILL:  state_d = S_ROT;
						ACT_READ:  state_d = S_RADDR;
						ACT_CLEAR: state_d = S_CLEAR;
						ACT_NONE:  state_d = S_DONE;
					endcase
				end
			end
			S_ROT:    state_d = S_CLIP;
			S_CLIP:   state_d = clip_empty ? S_DONE : S_SETUP;
			S_SETUP:  state_d = S_FILL;
			S_FILL:   state_d = (col_last && row_last) ? S_DONE : S_FILL;
			S_CLEAR:  state_d = clr_last ? S_DONE : S_CLEAR;
			S_RADDR:  state_d = rd_outside ? S_DONE : S_RISSUE;
			S_RISSUE: state_d = S_RDATA;
			S_RDATA:  state_d = S_DONE;
			S_DONE:   state_d = (!rsp_valid_q || !rsp_stall) ? S_IDLE : S_DONE;
			default:  state_d = S_IDLE;
		endcase
	end

	// outputs of the sequencer
	always_comb begin
		cmd_stall = 1'b1;
		wr_en     = 1'b0;
		wr_data   = cmd_q.color;
		rd_en     = 1'b0;
		load      = 1'b0;
		unique case (state_q)
			S_IDLE:   cmd_stall = 1'b0;
			S_FILL:   wr_en = 1'b1;
			S_CLEAR: begin
				wr_en   = 1'b1;
				wr_data = WHITE;
			end
			S_RISSUE: rd_en = 1'b1;
			S_DONE:   load = !rsp_valid_q || !rsp_stall;
			default:  ;
		endcase
	end

	assign wr_addr = addr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			rsp_valid_q <= load || (rsp_valid_q && rsp_stall);
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (load) begin
			rsp_q <= res_q;
		end
		unique case (state_q)
			S_IDLE: begin
				if (accept) begin
					cmd_q               <= cmd;
					addr_q              <= '0;
					res_q.pixel         <= '0;
					res_q.outside       <= 1'b0;
					res_q.written_count <= (action_t'(cmd.action) == ACT_CLEAR) ?
						CNT_W'(DEPTH) : '0;
				end
			end
			S_ROT: begin
				// landscape maps (x, y, w, h) to (W-(y+h), x, h, w)
				if (cmd_q.landscape) begin
					rx_q <= coord_t'(PANEL_WIDTH) -
						(sx12(cmd_q.y_pos) + sx12(cmd_q.rect_height));
					ry_q <= sx12(cmd_q.x_pos);
					rw_q <= sx12(cmd_q.rect_height);
					rh_q <= sx12(cmd_q.rect_width);
				end else begin
					rx_q <= sx12(cmd_q.x_pos);
					ry_q <= sx12(cmd_q.y_pos);
					rw_q <= sx12(cmd_q.rect_width);
					rh_q <= sx12(cmd_q.rect_height);
				end
			end
			S_CLIP: begin
				cx_q    <= CW'(xl);
				cy_q    <= RW'(yl);
				cw_q    <= CW'(wc);
				ch_q    <= RW'(hc);
				empty_q <= clip_empty;
			end
			S_SETUP: begin
				addr_q              <= base_d;
				row_base_q          <= base_d;
				col_q               <= '0;
				row_q               <= '0;
				res_q.written_count <= CNT_W'(area_d);
			end
			S_FILL: begin
				if (col_last) begin
					row_base_q <= row_base_q + ADDR_W'(PANEL_WIDTH);
					addr_q     <= row_base_q + ADDR_W'(PANEL_WIDTH);
					col_q      <= '0;
					row_q      <= row_q + RW'(1);
				end else begin
					addr_q <= addr_q + ADDR_W'(1);
					col_q  <= col_q + CW'(1);
				end
			end
			S_CLEAR: addr_q <= addr_q + ADDR_W'(1);
			S_RADDR: begin
				res_q.outside <= rd_outside;
				// the address is only used when the coordinates are in range, so take them as unsigned
				addr_q <= ADDR_W'($unsigned(RW'(cmd_q.y_pos))) * ADDR_W'(PANEL_WIDTH) +
					ADDR_W'($unsigned(CW'(cmd_q.x_pos)));
			end
			S_RISSUE: ;
			S_RDATA:  res_q.pixel <= rd_data;
			S_DONE:   ;
			default:  ;
		endcase
	end

	crfe_ram #(
		.WIDTH (PIX_W),
		.DEPTH (DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (addr_q),
		.rd_data (rd_data)
	);

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`AST_HOLDS(a_wr_in_store, clk, arst_n, wr_en |-> (wr_addr <= ADDR_W'(DEPTH - 1)), "write past store")
	`AST_HOLDS(a_fill_not_empty, clk, arst_n, (state_q == S_FILL) |-> !empty_q, "empty fill")
	`AST_HOLDS(a_accept_busy, clk, arst_n, accept |=> (state_q != S_IDLE), "idle after accept")
	`AST_HOLDS(a_rsp_from_done, clk, arst_n, $rose(rsp_valid) |-> ($past(state_q) == S_DONE), "early rsp")
	`AST_NEVER(a_rw_overlap, clk, arst_n, wr_en && rd_en, "store read during a write sweep")

endmodule

`default_nettype wire
